FILE: rtl/oxygen_level_stability_monitor_macros.svh
// assertion macros shared by the oxygen level stability monitor
`ifndef OXYGEN_LEVEL_STABILITY_MONITOR_MACROS_SVH
`define OXYGEN_LEVEL_STABILITY_MONITOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define OLSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define OLSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/olsm_pkg.sv
// shared types, constants and widths of the oxygen level stability monitor
package olsm_pkg;

    localparam int WINDOW_DEF     = 15;

    localparam int SAMPLE_W       = 16;
    localparam int O2_W           = 14;
    localparam int CAL_W          = 15;
    localparam int THR_W          = 14;

    localparam int O2_REF_CENTI   = 2090;
    localparam int O2_MAX_CENTI   = 9990;
    localparam int CAL_MIN_COUNTS = 12;
    localparam int CAL_RESET      = 1280;
    localparam int THRESH_RESET   = 10;

    // sample magnitude times reference, and calibration times saturation limit
    localparam int NUM_W          = 27;
    localparam int LIM_W          = 29;
    localparam int DCNT_W         = $clog2(O2_W);

    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int REG_SEL_BIT    = 2;

    localparam logic REG_IDX_CAL  = 1'b0;
    localparam logic REG_IDX_THR  = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_WR   = 8'b0001_0000,
        S_SCAN = 8'b0010_0000,
        S_LAST = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic chk;
        logic div;
        logic wr;
        logic scan;
        logic fold;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic quick;
        logic div_last;
        logic full_next;
        logic scan_last;
    } t_sts;

endpackage

FILE: rtl/olsm_ifs.sv
// item channels: converter samples in, oxygen results out
interface olsm_smp_if;
    import olsm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface olsm_res_if;
    import olsm_pkg::*;

    logic            valid;
    logic            ready;
    logic [O2_W-1:0] oxygen_centipercent;
    logic            is_stable;

    modport source (output valid, output oxygen_centipercent, output is_stable, input ready);
    modport sink   (input valid, input oxygen_centipercent, input is_stable, output ready);
endinterface

FILE: rtl/olsm_regs.sv
// apb configuration registers: calibration counts and stability threshold
module olsm_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [olsm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [olsm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [olsm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [olsm_pkg::CAL_W-1:0]       o_cal,
    output logic [olsm_pkg::THR_W-1:0]       o_thr
);
    import olsm_pkg::*;

    logic [CAL_W-1:0] r_cal;
    logic [THR_W-1:0] r_thr;
    logic             wr_en;
    logic             sel;

    assign pready = 1'b1;
    assign sel    = paddr[REG_SEL_BIT];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= CAL_W'(CAL_RESET);
            r_thr <= THR_W'(THRESH_RESET);
        end else if (wr_en) begin
            unique case (sel)
                REG_IDX_CAL: r_cal <= pwdata[CAL_W-1:0];
                REG_IDX_THR: r_thr <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_IDX_CAL: prdata = APB_DATA_W'(r_cal);
            REG_IDX_THR: prdata = APB_DATA_W'(r_thr);
            default:     prdata = '0;
        endcase
    end

    assign o_cal = r_cal;
    assign o_thr = r_thr;
endmodule

FILE: rtl/olsm_ctrl.sv
// sequencer: steps one item through scaling, division, ring write and scan
module olsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  olsm_pkg::t_sts i_sts,
    output olsm_pkg::t_cmd o_cmd
);
    import olsm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.quick ? S_WR : S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = i_sts.full_next ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_LAST;
            end
            S_LAST: begin
                o_cmd.fold = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load)           n_out_vld = 1'b1;
        else if (r_out_vld && i_out_ready)     n_out_vld = 1'b0;
        else                                   n_out_vld = r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
endmodule

FILE: rtl/olsm_datapath.sv
// scaling multipliers, serial divider, ring memory and min/max scan
module olsm_datapath #(
    parameter int WINDOW = olsm_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  olsm_pkg::t_cmd                    i_cmd,
    output olsm_pkg::t_sts                    o_sts,
    input  logic signed [olsm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [olsm_pkg::CAL_W-1:0]        i_cal,
    input  logic [olsm_pkg::THR_W-1:0]        i_thr,
    output logic [olsm_pkg::O2_W-1:0]         o_o2,
    output logic                              o_stable
);
    import olsm_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);

    logic signed [SAMPLE_W-1:0] r_sample;
    logic [NUM_W-1:0]           r_num;
    logic [LIM_W-1:0]           r_lim;
    logic                       r_zero;
    logic [CAL_W-1:0]           r_rem;
    logic [O2_W-1:0]            r_dnum;
    logic [O2_W-1:0]            r_quo;
    logic [DCNT_W-1:0]          r_dcnt;

    logic [O2_W-1:0]            mem [WINDOW];
    logic [IDX_W-1:0]           r_wpos;
    logic [FILL_W-1:0]          r_fill;
    logic                       r_full;
    logic [IDX_W-1:0]           r_raddr;
    logic [O2_W-1:0]            r_rdata;
    logic                       r_rv;
    logic [O2_W-1:0]            r_mn;
    logic [O2_W-1:0]            r_mx;

    logic [O2_W-1:0]            r_o2;
    logic                       r_stb;

    logic                       sat;
    logic [CAL_W:0]             trial;
    logic [CAL_W:0]             diff;
    logic                       ge;
    logic [O2_W-1:0]            spread;

    // quotient would pass the saturation limit
    assign sat   = LIM_W'(r_num) >= r_lim;
    assign trial = {r_rem, r_dnum[O2_W-1]};
    assign diff  = trial - {1'b0, i_cal};
    assign ge    = trial >= {1'b0, i_cal};
    assign spread = r_mx - r_mn;

    assign o_sts.quick     = r_zero || sat;
    assign o_sts.div_last  = (r_dcnt == DCNT_W'(O2_W - 1));
    assign o_sts.full_next = (r_fill >= FILL_W'(WINDOW - 1));
    assign o_sts.scan_last = (r_raddr == IDX_W'(WINDOW - 1));

    // scaling and restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_sample <= i_sample;
        if (i_cmd.mul) begin
            r_num  <= NUM_W'(r_sample[SAMPLE_W-2:0]) * NUM_W'(O2_REF_CENTI);
            r_lim  <= LIM_W'(i_cal) * LIM_W'(O2_MAX_CENTI + 1);
            r_zero <= r_sample[SAMPLE_W-1] || (r_sample == '0)
                      || (i_cal <= CAL_W'(CAL_MIN_COUNTS));
        end
        if (i_cmd.chk) begin
            r_dcnt <= '0;
            r_dnum <= r_num[O2_W-1:0];
            r_rem  <= CAL_W'(r_num[NUM_W-1:O2_W]);
            priority if (r_zero) r_quo <= '0;
            else if (sat)        r_quo <= O2_W'(O2_MAX_CENTI);
            else                 r_quo <= '0;
        end
        if (i_cmd.div) begin
            r_rem  <= ge ? diff[CAL_W-1:0] : trial[CAL_W-1:0];
            r_quo  <= {r_quo[O2_W-2:0], ge};
            r_dnum <= {r_dnum[O2_W-2:0], 1'b0};
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // ring memory, one write or one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr)   mem[r_wpos] <= r_quo;
        if (i_cmd.scan) r_rdata     <= mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_fill <= '0;
        end else if (i_cmd.wr) begin
            r_wpos <= (r_wpos == IDX_W'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
            if (r_fill != FILL_W'(WINDOW)) r_fill <= r_fill + 1'b1;
        end
    end

    // min/max over the ring, data folded in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_full  <= o_sts.full_next;
            r_raddr <= '0;
            r_rv    <= 1'b0;
            r_mn    <= '1;
            r_mx    <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_raddr <= r_raddr + 1'b1;
                r_rv    <= 1'b1;
            end
            if ((i_cmd.scan && r_rv) || i_cmd.fold) begin
                if (r_rdata < r_mn) r_mn <= r_rdata;
                if (r_rdata > r_mx) r_mx <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o2  <= r_quo;
            r_stb <= r_full && (spread < i_thr);
        end
    end

    assign o_o2     = r_o2;
    assign o_stable = r_stb;
endmodule

FILE: rtl/oxygen_level_stability_monitor.sv
// top level: oxygen scaling with ring-window stability flag, apb configured
// the ring is scanned only once it is full; zero or saturated values skip the
// divider
// one item at a time: a new item is taken only back in idle, after the 14-step serial
// divider and the scan of the single-port ring memory
// reset: synchronous active-low; registers back to defaults, ring empty
module oxygen_level_stability_monitor #(
    parameter int WINDOW = olsm_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    olsm_smp_if.sink                        i_smp,
    olsm_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [olsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [olsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [olsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import olsm_pkg::*;

`include "oxygen_level_stability_monitor_macros.svh"

    // configuration values seen by the datapath
    logic [CAL_W-1:0] cal;
    logic [THR_W-1:0] thr;

    // controller to datapath commands and status
    t_cmd cmd;
    t_sts sts;

    olsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (cal),
        .o_thr   (thr)
    );

    // sequencer owns the handshakes; the result register waits for the sink
    // while the block is already free to take the next item
    olsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    olsm_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_sample (i_smp.adc_sample),
        .i_cal    (cal),
        .i_thr    (thr),
        .o_o2     (o_res.oxygen_centipercent),
        .o_stable (o_res.is_stable)
    );

    // a result load never overwrites an item still waiting at the output
    `OLSM_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !(o_res.valid && !o_res.ready), "result overwritten before it was taken")
    // a loaded result shows up as valid in the next cycle
    `OLSM_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, cmd.out_load, o_res.valid, "loaded result not presented")
    // an accepted item makes the block busy
    `OLSM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_smp.valid && i_smp.ready, !i_smp.ready, "input still ready after accepting an item")
    // results stay within the saturation limit
    `OLSM_ASSERT_NOW(a_o2_range, i_clk, i_rst_n, o_res.valid, o_res.oxygen_centipercent <= O2_W'(O2_MAX_CENTI), "oxygen result above saturation limit")

endmodule

FILE: bench/tb_oxygen_level_stability_monitor.sv
// self-checking bench for the oxygen level stability monitor
`timescale 1ns / 1ps

module tb_oxygen_level_stability_monitor;
    import olsm_pkg::*;

    localparam int RING_DEPTH    = WINDOW_DEF;
    // settle time after the queues empty: the ring depth plus a margin
    localparam int SETTLE_CYCLES = RING_DEPTH + 25;
    localparam int PHASE_ITEMS   = 250;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // one expected oxygen reading as the result channel carries it
    typedef struct packed {
        logic [O2_W-1:0] centi;
        logic            stable;
    } t_reading;

    // receiver stall behavior, switched at random intervals
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_JITTER,
        RX_LONG
    } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    olsm_smp_if smp ();
    olsm_res_if res ();

    oxygen_level_stability_monitor #(
        .WINDOW(RING_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // predictor state: own copy of the ring, its pointers and the registers
    // ------------------------------------------------------------------
    logic [O2_W-1:0]  o2_ring [RING_DEPTH];
    int unsigned      ring_pos;
    int unsigned      ring_fill;
    logic [CAL_W-1:0] cal_counts;
    logic [THR_W-1:0] spread_limit;

    t_reading readings_due[$];     // expected readings, oldest first
    t_sample  pending_samples[$];  // samples still to be offered

    int unsigned error_count;

    // driver and receiver pacing
    int       burst_left;
    int       gap_left;
    int       stall_left;
    int       rx_mode_left;
    t_rx_mode rx_mode;

    // sample to hundredths of a percent against the air calibration
    function automatic logic [O2_W-1:0] centi_from_sample(t_sample s);
        int num;
        int quot;
        // zero or negative readings and a dead calibration both give 0
        if (s <= 0 || cal_counts <= CAL_MIN_COUNTS)
            return '0;
        num  = s;
        quot = (num * O2_REF_CENTI) / int'(cal_counts);
        if (quot > O2_MAX_CENTI)
            return O2_W'(O2_MAX_CENTI);
        return O2_W'(quot);
    endfunction

    // writes the scaled value into the ring and works out the stable flag
    function automatic t_reading predict_reading(t_sample s);
        t_reading        r;
        logic [O2_W-1:0] lo;
        logic [O2_W-1:0] hi;
        r.centi  = centi_from_sample(s);
        r.stable = 1'b0;
        o2_ring[ring_pos] = r.centi;
        ring_pos = (ring_pos == RING_DEPTH - 1) ? 0 : ring_pos + 1;
        if (ring_fill < RING_DEPTH)
            ring_fill++;
        // the spread is only looked at once every slot holds a real value
        if (ring_fill == RING_DEPTH) begin
            lo = o2_ring[0];
            hi = o2_ring[0];
            for (int i = 1; i < RING_DEPTH; i++) begin
                if (o2_ring[i] < lo)
                    lo = o2_ring[i];
                if (o2_ring[i] > hi)
                    hi = o2_ring[i];
            end
            r.stable = ((hi - lo) < spread_limit);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // posedge side: accept samples into the predictor, check results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && smp.valid && smp.ready) begin
            readings_due.push_back(predict_reading(smp.adc_sample));
            void'(pending_samples.pop_front());
            // count the burst down; when it ends, maybe open a gap before the next item
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0) begin
                if ($urandom_range(0, 9) == 0)
                    burst_left = $urandom_range(50, 150);  // long gap-free stretch
                else
                    burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
            end
        end
        if (i_rst_n && res.valid && res.ready) begin
            if (readings_due.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected reading: centi=%0d stable=%0b",
                             res.oxygen_centipercent, res.is_stable);
                error_count++;
            end else begin
                if (res.oxygen_centipercent !== readings_due[0].centi ||
                    res.is_stable !== readings_due[0].stable) begin
                    if (error_count < 10)
                        $display("reading mismatch: expected centi=%0d stable=%0b, got centi=%0d stable=%0b",
                                 readings_due[0].centi, readings_due[0].stable,
                                 res.oxygen_centipercent, res.is_stable);
                    error_count++;
                end
                void'(readings_due.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // negedge side: sample driver in bursts, receiver with its own stalls
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        // gaps only start right after an accept, so valid is never retracted
        if (gap_left > 0) begin
            gap_left--;
            smp.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            smp.valid      <= 1'b1;
            smp.adc_sample <= pending_samples[0];
        end else begin
            smp.valid <= 1'b0;
        end

        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 400);
        end else begin
            rx_mode_left--;
        end

        if (stall_left > 0) begin
            stall_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
            case (rx_mode)
                RX_JITTER: begin
                    if ($urandom_range(0, 1) == 1)
                        stall_left = $urandom_range(1, 3);
                end
                RX_LONG: begin
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(5, 50);
                end
                default: stall_left = 0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // register access and stimulus
    // ------------------------------------------------------------------
    // setup cycle, then access cycle held until pready
    task automatic apb_write(logic idx, logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IDX_CAL)
            cal_counts = value[CAL_W-1:0];
        else
            spread_limit = value[THR_W-1:0];
    endtask

    // block idle: everything offered, every reading back, pipeline drained
    task automatic wait_quiet();
        while (pending_samples.size() > 0 || readings_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly steady runs with small noise so the stable flag toggles,
    // the rest is full-range noise and spikes that break the runs
    task automatic queue_sample_mix(int count);
        int left;
        int run_len;
        int base;
        int amp;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                run_len = $urandom_range(8, 48);
                base    = int'($urandom_range(0, 8000)) - 50;
                amp     = $urandom_range(0, 6);
                for (int i = 0; i < run_len && left > 0; i++) begin
                    if ($urandom_range(0, 39) == 0)
                        pending_samples.push_back(t_sample'($urandom));
                    else
                        pending_samples.push_back(
                            t_sample'(base + int'($urandom_range(0, 2 * amp)) - amp));
                    left--;
                end
            end else begin
                pending_samples.push_back(t_sample'($urandom));
                left--;
            end
        end
    endtask

    task automatic run_setting(int unsigned cal, int unsigned thr);
        wait_quiet();
        apb_write(REG_IDX_CAL, cal);
        apb_write(REG_IDX_THR, thr);
        queue_sample_mix(PHASE_ITEMS);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        smp.valid      = 1'b0;
        smp.adc_sample = '0;
        res.ready      = 1'b0;

        ring_pos     = 0;
        ring_fill    = 0;
        cal_counts   = CAL_W'(CAL_RESET);
        spread_limit = THR_W'(THRESH_RESET);
        error_count  = 0;
        burst_left   = 1;
        gap_left     = 0;
        stall_left   = 0;
        rx_mode_left = 0;
        rx_mode      = RX_STEADY;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, at reset calibration and threshold: sign and zero
        // saturation, smallest positive, edge of the 99.9 percent clamp,
        // full scale, then a flat run long enough to flush the ring stable
        pending_samples.push_back(t_sample'(-32768));
        pending_samples.push_back(t_sample'(-1));
        pending_samples.push_back(t_sample'(0));
        pending_samples.push_back(t_sample'(1));
        pending_samples.push_back(t_sample'(2));
        pending_samples.push_back(t_sample'(6118));
        pending_samples.push_back(t_sample'(6119));
        pending_samples.push_back(t_sample'(32767));
        pending_samples.push_back(t_sample'(16384));
        repeat (16) pending_samples.push_back(t_sample'(3000));

        run_setting(1280, 50);
        run_setting(0, 10);                 // dead calibration: all zero, flat
        run_setting(12, 0);                 // edge of low calibration, zero threshold
        run_setting(13, 9990);              // first live calibration, mostly clamped
        run_setting(32767, 16383);          // full-scale registers, always stable once full
        run_setting($urandom_range(13, 4000), $urandom_range(1, 300));
        run_setting(600, 20);

        wait_quiet();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
